/* rtl/core/bfa_pkg.sv */
// Shared types and constants for the buddy frame allocator.
// Used by bfa_walk and buddy_frame_allocator; no dependencies.
package bfa_pkg;

  // Field widths fixed by the interface.
  localparam int ReqW  = 23;
  localparam int AddrW = 32;

  // Default geometry and register reset value.
  localparam int LeafLog2Def  = 10;
  localparam int FrameLog2Def = 12;
  localparam logic [AddrW-1:0] RegionBaseRst = 32'h1000_0000;

  // Operation codes.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Status codes.
  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FAIL = 1'b1
  } status_e;

  // Input word.
  typedef struct packed {
    logic             op;
    logic [ReqW-1:0]  request_bytes;
    logic [AddrW-1:0] block_address;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic             status;
    logic [AddrW-1:0] granted_address;
  } out_word_t;

  // Walk sequencer states, one-hot.
  typedef enum logic [13:0] {
    S_CLEAR = 14'h0001,
    S_IDLE  = 14'h0002,
    S_SIZE  = 14'h0004,
    S_ARD   = 14'h0008,
    S_AEV   = 14'h0010,
    S_CLIMB = 14'h0020,
    S_SCHK  = 14'h0040,
    S_SPLR  = 14'h0080,
    S_SPLL  = 14'h0100,
    S_FRD   = 14'h0200,
    S_FEV   = 14'h0400,
    S_MCHK  = 14'h0800,
    S_MEV   = 14'h1000,
    S_MWB   = 14'h2000
  } state_e;

endpackage

/* rtl/core/buddy_frame_allocator.sv */
// Binary buddy frame allocator top level: region base register, tree walk
// and free-mark memory. Depends on bfa_pkg, bfa_mark_mem and bfa_walk.
//
// A word is taken when start_i is high and busy_o is low. Its one result word
// shows on res_o for a single cycle with done_o high, the cycle after the walk
// finishes, and cannot be held off; busy_o is already low in that cycle.
// After reset the free-mark memory is cleared node by node, which keeps busy_o
// high until every node has been written. Every word goes through the size
// check, stepping once per power of two from the frame size up to the request.
// An allocate then reads each tree node visited by the depth-first search,
// steps back up or across the tree, splits blocks and finishes; a free reads
// its node, merges level by level and finishes. The registered read of the
// mark memory sets the per-node cost, so a search over a crowded tree can
// take long.
module buddy_frame_allocator
  import bfa_pkg::*;
#(
  parameter int LEAF_LOG2  = LeafLog2Def,
  parameter int FRAME_LOG2 = FrameLog2Def
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  in_word_t         in_i,
  output logic             done_o,
  output out_word_t        res_o,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i
);

  logic [AddrW-1:0] base_q;
  logic             rd_en, rd_data, wr_en, wr_data;
  logic [LEAF_LOG2:0] rd_addr, wr_addr;

  // Region base register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= RegionBaseRst;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Tree walk sequencer.
  bfa_walk #(
    .LeafLog2 (LEAF_LOG2),
    .FrameLog2(FRAME_LOG2)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .base_i   (base_q),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .res_o    (res_o),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data)
  );

  // Free marks, one per node.
  bfa_mark_mem #(
    .NodeW(LEAF_LOG2 + 1)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

`ifndef SYNTHESIS
  // A result word only ends an operation that was in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result word without operation");

  // Failures never report an address.
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status == ST_FAIL
    |-> res_o.granted_address == '0) else $error("failure with address");

  // An accepted word keeps the block busy, with no result, in the cycle after it is taken.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o) else $error("word not taken");
`endif

endmodule

/* rtl/core/bfa_mark_mem.sv */
// Free-mark memory: one bit per tree node, one write and one read port.
// Read data is registered. Depends on nothing.
module bfa_mark_mem #(
  parameter int NodeW = 11
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [NodeW-1:0] rd_addr_i,
  output logic             rd_data_o,
  input  logic             wr_en_i,
  input  logic [NodeW-1:0] wr_addr_i,
  input  logic             wr_data_i
);

  logic mem_q [2**NodeW];
  logic rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/bfa_walk.sv */
// Sequencer that walks the buddy tree held in the free-mark memory.
// Depends on bfa_pkg; drives the ports of one bfa_mark_mem.
module bfa_walk
  import bfa_pkg::*;
#(
  parameter int LeafLog2  = LeafLog2Def,
  parameter int FrameLog2 = FrameLog2Def
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  in_word_t                in_i,
  input  logic [AddrW-1:0]        base_i,
  output logic                    busy_o,
  output logic                    done_o,
  output out_word_t               res_o,
  output logic                    rd_en_o,
  output logic [LeafLog2:0]       rd_addr_o,
  input  logic                    rd_data_i,
  output logic                    wr_en_o,
  output logic [LeafLog2:0]       wr_addr_o,
  output logic                    wr_data_o
);

  localparam int NodeW     = LeafLog2 + 1;
  localparam int RegionLog2 = LeafLog2 + FrameLog2;
  localparam int LgW       = $clog2(RegionLog2 + 1);
  localparam int DepthW    = $clog2(LeafLog2 + 1);
  localparam int OffW      = LeafLog2 + FrameLog2;
  localparam logic [LgW:0]        RegionLg = (LgW + 1)'(RegionLog2);
  localparam logic [LgW-1:0]      FrameLg  = LgW'(FrameLog2);
  localparam logic [DepthW-1:0]   LeafD    = DepthW'(LeafLog2);
  localparam logic [NodeW-1:0]    RootNode = NodeW'(1);

  state_e             state_q, state_d;
  logic               op_q, op_d;
  logic [ReqW-1:0]    req_q, req_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [LgW-1:0]     need_q, need_d;
  logic [NodeW-1:0]   node_q, node_d;
  logic [DepthW-1:0]  depth_q, depth_d;
  logic [NodeW-1:0]   clr_q, clr_d;
  logic               done_q, done_d;
  out_word_t          res_q, res_d;

  logic               too_big, grow;
  logic               can_split;
  logic [AddrW-1:0]   off;
  logic               bad_off;
  logic [LgW-1:0]     fdiff;
  logic [NodeW-1:0]   fnode;
  logic [LeafLog2-1:0] lmask, leaf;
  logic [OffW-1:0]    boff;
  logic [NodeW-1:0]   left, buddy;

  // Request against region size and ceil log2 stepping.
  assign too_big = (RegionLog2 < ReqW) &&
                   ({1'b0, req_q} > ((ReqW + 1)'(1) << RegionLog2));
  assign grow    = ((LgW + 1)'(need_q) < RegionLg) && (need_q < LgW'(ReqW)) &&
                   ({1'b0, req_q} > ((ReqW + 1)'(1) << need_q));

  // A block of this node's size still halves toward the request.
  assign can_split = (depth_q < LeafD) &&
                     (((LgW + 1)'(need_q) + (LgW + 1)'(depth_q)) < RegionLg);

  // Free: offset checks and node index of the block.
  assign off     = addr_q - base_i;
  assign bad_off = ((AddrW + 1)'(off) >> RegionLog2) != '0 ||
                   (off & ~({AddrW{1'b1}} << need_q)) != '0;
  assign fdiff   = LgW'(RegionLg) - need_q;
  assign fnode   = (RootNode << DepthW'(fdiff)) | NodeW'(off >> need_q);

  // Alloc: byte offset of the found block.
  assign lmask = ~({LeafLog2{1'b1}} << depth_q);
  assign leaf  = (node_q[LeafLog2-1:0] & lmask) << (LeafD - depth_q);
  assign boff  = OffW'(leaf) << FrameLog2;

  assign left  = {node_q[NodeW-2:0], 1'b0};
  assign buddy = {node_q[NodeW-1:1], ~node_q[0]};

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    req_d     = req_q;
    addr_d    = addr_q;
    need_d    = need_q;
    node_d    = node_q;
    depth_d   = depth_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    res_d     = res_q;
    rd_en_o   = 1'b0;
    rd_addr_o = node_q;
    wr_en_o   = 1'b0;
    wr_addr_o = node_q;
    wr_data_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        wr_data_o = (clr_q == RootNode);
        clr_d     = clr_q + NodeW'(1);
        if (clr_q == {NodeW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          op_d    = in_i.op;
          req_d   = in_i.request_bytes;
          addr_d  = in_i.block_address;
          need_d  = FrameLg;
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        if (too_big) begin
          done_d  = 1'b1;
          res_d   = '{status: ST_FAIL, granted_address: '0};
          state_d = S_IDLE;
        end else if (grow) begin
          need_d = need_q + LgW'(1);
        end else if (op_q == OP_ALLOC) begin
          node_d  = RootNode;
          depth_d = '0;
          state_d = S_ARD;
        end else if (bad_off) begin
          done_d  = 1'b1;
          res_d   = '{status: ST_FAIL, granted_address: '0};
          state_d = S_IDLE;
        end else begin
          node_d  = fnode;
          state_d = S_FRD;
        end
      end
      S_ARD: begin
        rd_en_o = 1'b1;
        state_d = S_AEV;
      end
      S_AEV: begin
        if (rd_data_i) begin
          wr_en_o = 1'b1;
          state_d = S_SCHK;
        end else if (can_split) begin
          node_d  = left;
          depth_d = depth_q + DepthW'(1);
          state_d = S_ARD;
        end else begin
          state_d = S_CLIMB;
        end
      end
      S_CLIMB: begin
        if (node_q == RootNode) begin
          done_d  = 1'b1;
          res_d   = '{status: ST_FAIL, granted_address: '0};
          state_d = S_IDLE;
        end else if (node_q[0]) begin
          node_d  = node_q >> 1;
          depth_d = depth_q - DepthW'(1);
        end else begin
          node_d  = node_q + NodeW'(1);
          state_d = S_ARD;
        end
      end
      S_SCHK: begin
        if (can_split) begin
          state_d = S_SPLR;
        end else begin
          done_d  = 1'b1;
          res_d   = '{status: ST_OK, granted_address: base_i + AddrW'(boff)};
          state_d = S_IDLE;
        end
      end
      S_SPLR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = {node_q[NodeW-2:0], 1'b1};
        wr_data_o = 1'b1;
        state_d   = S_SPLL;
      end
      S_SPLL: begin
        wr_en_o   = 1'b1;
        wr_addr_o = left;
        node_d    = left;
        depth_d   = depth_q + DepthW'(1);
        state_d   = S_SCHK;
      end
      S_FRD: begin
        rd_en_o = 1'b1;
        state_d = S_FEV;
      end
      S_FEV: begin
        if (rd_data_i) begin
          done_d  = 1'b1;
          res_d   = '{status: ST_FAIL, granted_address: '0};
          state_d = S_IDLE;
        end else begin
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (node_q == RootNode) begin
          wr_en_o   = 1'b1;
          wr_data_o = 1'b1;
          done_d    = 1'b1;
          res_d     = '{status: ST_OK, granted_address: '0};
          state_d   = S_IDLE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = buddy;
          state_d   = S_MEV;
        end
      end
      S_MEV: begin
        if (rd_data_i) begin
          // Buddy is free too: clear both halves and move up.
          wr_en_o   = 1'b1;
          wr_addr_o = buddy;
          state_d   = S_MWB;
        end else begin
          wr_en_o   = 1'b1;
          wr_data_o = 1'b1;
          done_d    = 1'b1;
          res_d     = '{status: ST_OK, granted_address: '0};
          state_d   = S_IDLE;
        end
      end
      S_MWB: begin
        wr_en_o = 1'b1;
        node_d  = node_q >> 1;
        state_d = S_MCHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    req_q   <= req_d;
    addr_q  <= addr_d;
    need_q  <= need_d;
    node_q  <= node_d;
    depth_q <= depth_d;
    res_q   <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
